/* rtl/mopr_pkg.sv */
`timescale 1ns / 1ps

package mopr_pkg;

  // Default panel geometry.
  localparam int DEF_FRAME_WIDTH  = 96;
  localparam int DEF_FRAME_HEIGHT = 16;

  // The write address is one byte wide, so no more than 256 bytes are ever reachable.
  localparam int ADDR_W        = 8;
  localparam int STORE_MAX_DEP = 256;

  // Input command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_WR_OK  = 2'd0;
  localparam logic [1:0] KIND_WR_ERR = 2'd1;
  localparam logic [1:0] KIND_MSG    = 2'd2;

  // Bus message bytes.
  localparam logic [7:0] CTRL_CMD      = 8'h80;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Message steps within a page.
  localparam logic [7:0] STEP_PAGE    = 8'd0;
  localparam logic [7:0] STEP_COL_LOW = 8'd1;
  localparam logic [7:0] STEP_COL_HI  = 8'd2;
  localparam int         CMD_STEPS    = 3;

  // Microcode.
  typedef logic [2:0] upc_t;

  localparam upc_t U_FETCH  = 3'd0;
  localparam upc_t U_DISP   = 3'd1;
  localparam upc_t U_RD0    = 3'd2;
  localparam upc_t U_GATHER = 3'd3;
  localparam upc_t U_EMIT   = 3'd4;
  localparam upc_t U_WRITE  = 3'd5;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_LATCH    = 3'd1,
    ACT_RD_FIRST = 3'd2,
    ACT_GATHER   = 3'd3,
    ACT_EMIT_MSG = 3'd4,
    ACT_EMIT_WR  = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_IS_WRITE = 3'd2,
    C_IS_CMD   = 3'd3,
    C_ROW_MORE = 3'd4
  } cond_t;

  typedef struct packed {
    logic  wait_in;
    logic  wait_out;
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Control program.
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_NONE, cond: C_ALWAYS, target: U_FETCH};
    unique case (pc)
      U_FETCH:  w = '{1'b1, 1'b0, ACT_LATCH,    C_IS_WRITE, U_WRITE};
      U_DISP:   w = '{1'b0, 1'b0, ACT_NONE,     C_IS_CMD,   U_EMIT};
      U_RD0:    w = '{1'b0, 1'b0, ACT_RD_FIRST, C_NEXT,     U_FETCH};
      U_GATHER: w = '{1'b0, 1'b0, ACT_GATHER,   C_ROW_MORE, U_GATHER};
      U_EMIT:   w = '{1'b0, 1'b1, ACT_EMIT_MSG, C_ALWAYS,   U_FETCH};
      U_WRITE:  w = '{1'b0, 1'b1, ACT_EMIT_WR,  C_ALWAYS,   U_FETCH};
      default:  w = '{1'b0, 1'b0, ACT_NONE,     C_ALWAYS,   U_FETCH};
    endcase
    return w;
  endfunction

  // Frame store access between the sequencer and the store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              rd_ok;
  } store_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
  } store_rsp_t;

endpackage

/* rtl/mopr_if.sv */
`timescale 1ns / 1ps

interface mopr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] address;
  logic [7:0] byte_data;

  modport source (output valid, command, address, byte_data, input ready);
  modport sink   (input valid, command, address, byte_data, output ready);
endinterface

interface mopr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] control_byte;
  logic [7:0] payload;
  logic       frame_end;

  modport source (output valid, kind, control_byte, payload, frame_end, input ready);
  modport sink   (input valid, kind, control_byte, payload, frame_end, output ready);
endinterface

/* rtl/mopr_store.sv */
`timescale 1ns / 1ps

// Frame store: one write and one registered read per cycle. Entries never
// written read as zero through the valid bits, which reset clears at once.
module mopr_store import mopr_pkg::*; #(
  parameter int DEPTH = STORE_MAX_DEP
) (
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output store_rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr[AW-1:0]] <= 1'b1;
      end
      if (req.re) begin
        rvld_r <= req.rd_ok & vld_r[req.raddr[AW-1:0]];
      end
    end
  end

  assign rsp.data  = rdata_r;
  assign rsp.valid = rvld_r;

endmodule

/* rtl/mono_oled_page_refresh_unit.sv */
`timescale 1ns / 1ps

// Monochrome frame store with a page-transposing refresh sequencer. A write word
// (command 0) stores one byte of the row-major, LSB-leftmost frame and returns
// kind 0, or kind 1 when the address lies beyond the store. A refresh word
// (command 1) returns the next two-byte bus message of a frame: per 8-row page
// three command messages (control 0x80: 0xB0 plus page, 0x00, 0x10), then one
// data message (control 0x40) per column carrying that column's eight pixels,
// top row in bit 0; frame_end marks the last data message of the frame, and the
// next refresh word begins a fresh frame at page 0. Words are handled one at a
// time by a small microcoded sequencer. A write runs the fetch and write steps, a
// command message fetch, dispatch and emit; a data message adds a first read and a
// gather loop, eight reads on the store's one read port. The result register
// parts the two sides: a result word waiting on out_ch.ready does not stop the
// next word from being taken and worked on, and only adds cycles when that next
// word reaches its own emit step before the earlier result has been taken.
// The store needs no clearing pass: one valid bit per byte, cleared at reset,
// makes unwritten bytes read zero.
module mono_oled_page_refresh_unit import mopr_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input logic        clk,
  input logic        rst_n,
  mopr_in_if.sink    in_ch,
  mopr_out_if.source out_ch
);

  // Geometry derived from the panel size.
  localparam int LINE_BYTES  = FRAME_WIDTH / 8;
  localparam int STORE_BYTES = LINE_BYTES * FRAME_HEIGHT;
  localparam int PAGE_COUNT  = FRAME_HEIGHT / 8;
  localparam int MEM_DEPTH   = (STORE_BYTES < STORE_MAX_DEP) ? STORE_BYTES : STORE_MAX_DEP;
  localparam int IDX_W       = $clog2(STORE_BYTES + 1);
  localparam int STEP_END    = CMD_STEPS + FRAME_WIDTH;

  // Sequencer and datapath state.
  upc_t       upc_r, upc_nxt;
  logic [2:0] page_r;
  logic [7:0] step_r;
  logic [3:0] k_r;
  logic [7:0] acc_r;
  logic       cmd_r;
  logic [7:0] addr_r;
  logic [7:0] data_r;

  // Result word register.
  logic       out_valid_r;
  logic [1:0] kind_r;
  logic [7:0] ctrl_r;
  logic [7:0] payload_r;
  logic       frame_end_r;

  uword_t     uw;
  logic       out_free;
  logic       go;
  logic       take;
  logic       addr_ok;
  logic [7:0] col;
  logic [2:0] k_sel;
  logic [5:0] row;
  logic [IDX_W-1:0] idx;
  logic       pix;
  logic [2:0] k_prev;
  logic [8:0] step_inc;
  logic [3:0] page_inc;
  logic       page_done;
  logic       frame_done;
  logic [7:0] msg_ctrl;
  logic [7:0] msg_payload;

  store_req_t st_req;
  store_rsp_t st_rsp;

  assign uw = ucode(upc_r);

  // A step waits on the input word or on a free result slot as its control word says.
  assign out_free = !out_valid_r || out_ch.ready;
  assign go       = (!uw.wait_in || in_ch.valid) && (!uw.wait_out || out_free);
  assign in_ch.ready = uw.wait_in;

  always_comb begin
    case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_IS_WRITE: take = (in_ch.command == CMD_WRITE);
      C_IS_CMD:   take = (step_r < 8'(CMD_STEPS));
      C_ROW_MORE: take = (k_r != 4'd8);
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt = upc_r;
    if (go) begin
      upc_nxt = take ? uw.target : upc_t'(upc_r + 3'd1);
    end
  end

  // Column byte gathering: row page*8+k of the current column, one byte per cycle.
  // The column index stays fixed for the whole word, so its low bits pick the pixel.
  assign col   = step_r - 8'(CMD_STEPS);
  assign k_sel = (uw.act == ACT_RD_FIRST) ? 3'd0 : k_r[2:0];
  assign row   = {page_r, k_sel};
  assign idx   = IDX_W'(row) * IDX_W'(LINE_BYTES) + IDX_W'(col[7:3]);
  assign pix   = st_rsp.valid & st_rsp.data[col[2:0]];
  assign k_prev = 3'(k_r - 4'd1);

  // Bytes past the writable range have never been written and so read as zero.
  assign addr_ok = (int'(addr_r) < STORE_BYTES);

  always_comb begin
    st_req.we    = go && (uw.act == ACT_EMIT_WR) && addr_ok;
    st_req.waddr = addr_r;
    st_req.wdata = data_r;
    st_req.re    = go && ((uw.act == ACT_RD_FIRST) || (uw.act == ACT_GATHER));
    st_req.raddr = ADDR_W'(idx);
    st_req.rd_ok = (int'(idx) < MEM_DEPTH);
  end

  mopr_store #(
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rsp   (st_rsp)
  );

  // Message bytes and position update for the current refresh step.
  always_comb begin
    case (step_r)
      STEP_PAGE: begin
        msg_ctrl    = CTRL_CMD;
        msg_payload = CMD_PAGE_BASE + {5'd0, page_r};
      end
      STEP_COL_LOW: begin
        msg_ctrl    = CTRL_CMD;
        msg_payload = CMD_COL_LOW;
      end
      STEP_COL_HI: begin
        msg_ctrl    = CTRL_CMD;
        msg_payload = CMD_COL_HIGH;
      end
      default: begin
        msg_ctrl    = CTRL_DATA;
        msg_payload = acc_r;
      end
    endcase
  end

  assign step_inc   = {1'b0, step_r} + 9'd1;
  assign page_inc   = {1'b0, page_r} + 4'd1;
  assign page_done  = (int'(step_inc) >= STEP_END);
  assign frame_done = page_done && (int'(page_inc) >= PAGE_COUNT);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_FETCH;
      page_r      <= 3'd0;
      step_r      <= 8'd0;
      k_r         <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (go) begin
        case (uw.act)
          ACT_RD_FIRST: k_r <= 4'd1;
          ACT_GATHER:   k_r <= k_r + 4'd1;
          ACT_EMIT_MSG: begin
            out_valid_r <= 1'b1;
            if (frame_done) begin
              step_r <= 8'd0;
              page_r <= 3'd0;
            end else if (page_done) begin
              step_r <= 8'd0;
              page_r <= page_inc[2:0];
            end else begin
              step_r <= step_inc[7:0];
            end
          end
          ACT_EMIT_WR: out_valid_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (go) begin
      case (uw.act)
        ACT_LATCH: begin
          cmd_r  <= in_ch.command;
          addr_r <= in_ch.address;
          data_r <= in_ch.byte_data;
        end
        ACT_RD_FIRST: acc_r <= 8'd0;
        ACT_GATHER:   acc_r <= acc_r | (8'(pix) << k_prev);
        ACT_EMIT_MSG: begin
          kind_r      <= KIND_MSG;
          ctrl_r      <= msg_ctrl;
          payload_r   <= msg_payload;
          frame_end_r <= frame_done;
        end
        ACT_EMIT_WR: begin
          kind_r      <= (addr_ok && (cmd_r == CMD_WRITE)) ? KIND_WR_OK : KIND_WR_ERR;
          ctrl_r      <= 8'd0;
          payload_r   <= 8'd0;
          frame_end_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.control_byte = ctrl_r;
  assign out_ch.payload      = payload_r;
  assign out_ch.frame_end    = frame_end_r;

endmodule

/* rtl/mopr_checker.sv */
`timescale 1ns / 1ps

module mopr_checker import mopr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_control_byte,
  input logic [7:0] out_payload,
  input logic       out_frame_end
);

  // A held result word keeps its payload and kind until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(out_kind))
    else $error("result word changed while stalled");

  // Words are handled one at a time: no word is taken in the cycle after one was.
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input word taken on consecutive cycles");

  // The frame end mark only rides on a data message.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_kind == KIND_MSG && out_control_byte == CTRL_DATA)
    else $error("frame end on a non-data word");

  // Write results carry no message bytes.
  a_wr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_WR_OK || out_kind == KIND_WR_ERR)
      |-> out_control_byte == 8'd0 && out_payload == 8'd0 && !out_frame_end)
    else $error("write result carries message bytes");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind mono_oled_page_refresh_unit mopr_checker u_mopr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_control_byte (out_ch.control_byte),
  .out_payload      (out_ch.payload),
  .out_frame_end    (out_ch.frame_end)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the page refresh unit. Words are queued up front by
// the stimulus process, presented by a clocked driver and predicted the moment
// the block accepts them; a clocked monitor compares each result word against
// the oldest prediction, field by field.
module tb;
  import mopr_pkg::*;

  // Geometry under test; the block is built with the package defaults.
  localparam int FRAME_W     = DEF_FRAME_WIDTH;
  localparam int FRAME_H     = DEF_FRAME_HEIGHT;
  localparam int LINE_BYTES  = FRAME_W / 8;
  localparam int STORE_BYTES = LINE_BYTES * FRAME_H;
  localparam int PAGES       = FRAME_H / 8;
  localparam int MSGS_PER_PG = CMD_STEPS + FRAME_W;

  // Word counts at which the idling pattern changes, and the overall target.
  localparam int PHASE1_AT   = 350;
  localparam int PHASE2_AT   = 700;
  localparam int WORD_TARGET = 1020;
  localparam int DIRECTED_N  = 19;

  typedef struct {
    logic       command;
    logic [7:0] address;
    logic [7:0] byte_data;
    int         phase;
    bit         drain_first;
  } stim_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] control_byte;
    logic [7:0] payload;
    logic       frame_end;
  } bus_result_t;

  logic clk;
  logic rst_n;

  mopr_in_if  in_ch ();
  mopr_out_if out_ch ();

  mono_oled_page_refresh_unit #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_word_t  stim_words[$];
  bus_result_t pending_results[$];

  // Shadow copy of the frame store and of the refresh sequencer.
  logic [7:0] frame_img [STORE_BYTES] = '{default: 8'h00};
  logic [2:0] page_no      = '0;
  logic [7:0] step_no      = '0;
  logic       refresh_busy = 1'b0;

  int n_taken   = 0;
  int n_checked = 0;
  int n_errors  = 0;
  int n_queued  = 0;
  int run_phase = 0;

  // Works out the result word that one accepted input word causes, and
  // advances the shadow store and sequencer exactly as the block should.
  task automatic predict_result(input logic cmd, input logic [7:0] addr,
                                input logic [7:0] data, output bus_result_t r);
    int col;
    int idx;
    logic [7:0] col_bits;
    r = '0;
    if (cmd == CMD_WRITE) begin
      if (addr >= STORE_BYTES) begin
        r.kind = KIND_WR_ERR;
      end else begin
        frame_img[addr] = data;
        r.kind = KIND_WR_OK;
      end
    end else begin
      // A tick with no frame in progress opens a new one at the top page.
      if (!refresh_busy) begin
        refresh_busy = 1'b1;
        page_no = '0;
        step_no = '0;
      end
      r.kind = KIND_MSG;
      case (step_no)
        STEP_PAGE: begin
          r.control_byte = CTRL_CMD;
          r.payload = CMD_PAGE_BASE + 8'(page_no);
        end
        STEP_COL_LOW: begin
          r.control_byte = CTRL_CMD;
          r.payload = CMD_COL_LOW;
        end
        STEP_COL_HI: begin
          r.control_byte = CTRL_CMD;
          r.payload = CMD_COL_HIGH;
        end
        default: begin
          // Gather the column's eight pixels of this page, top row in bit 0.
          col = int'(step_no) - CMD_STEPS;
          col_bits = '0;
          for (int k = 0; k < 8; k++) begin
            idx = (int'(page_no) * 8 + k) * LINE_BYTES + col / 8;
            if (idx < STORE_BYTES) col_bits[k] = frame_img[idx][col % 8];
          end
          r.control_byte = CTRL_DATA;
          r.payload = col_bits;
        end
      endcase
      if (int'(step_no) + 1 >= MSGS_PER_PG) begin
        step_no = '0;
        if (int'(page_no) + 1 >= PAGES) begin
          // Last data message of the last page closes the frame.
          r.frame_end = 1'b1;
          page_no = '0;
          refresh_busy = 1'b0;
        end else begin
          page_no = page_no + 3'd1;
        end
      end else begin
        step_no = step_no + 8'd1;
      end
    end
  endtask

  // Appends one word to the stimulus queue. The phase follows from its place
  // in the run, and the first word of the random part and of each later phase
  // is held back until every outstanding result has come out.
  task automatic queue_word(input logic cmd, input logic [7:0] addr, input logic [7:0] data);
    stim_word_t w;
    w.command     = cmd;
    w.address     = addr;
    w.byte_data   = data;
    w.phase       = (n_queued < PHASE1_AT) ? 0 : (n_queued < PHASE2_AT) ? 1 : 2;
    w.drain_first = (n_queued == DIRECTED_N) || (n_queued == PHASE1_AT) ||
                    (n_queued == PHASE2_AT);
    stim_words.push_back(w);
    n_queued++;
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : safety_limit
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Every input of the block has a known value from time zero.
  initial begin : bus_defaults
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_WRITE;
    in_ch.address   = '0;
    in_ch.byte_data = '0;
    out_ch.ready    = 1'b0;
  end

  // Driver: predicts each word as it is accepted, then either holds the word
  // on the bus, presents the next one from the queue, or idles.
  always @(posedge clk) begin : drive_words
    bus_result_t r;
    stim_word_t nxt;
    logic accepted;
    logic present;
    int gap_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      accepted = in_ch.valid && in_ch.ready;
      if (accepted) begin
        predict_result(in_ch.command, in_ch.address, in_ch.byte_data, r);
        pending_results.push_back(r);
        n_taken <= n_taken + 1;
      end
      // A word that has not yet been taken stays on the bus unchanged.
      if (!(in_ch.valid && !in_ch.ready)) begin
        present = 1'b0;
        if (stim_words.size() != 0) begin
          nxt = stim_words[0];
          gap_pct = (nxt.phase == 0) ? 11 : (nxt.phase == 1) ? 85 : 0;
          present = ($urandom_range(99) >= gap_pct);
          if (nxt.drain_first && (accepted || n_taken != n_checked)) present = 1'b0;
        end
        if (present) begin
          void'(stim_words.pop_front());
          in_ch.command   <= nxt.command;
          in_ch.address   <= nxt.address;
          in_ch.byte_data <= nxt.byte_data;
          run_phase       <= nxt.phase;
        end
        in_ch.valid <= present;
      end
    end
  end

  // Monitor: checks every result word against the oldest prediction and
  // stalls the result channel at the rate the current phase calls for.
  always @(posedge clk) begin : check_results
    bus_result_t got;
    bus_result_t want;
    int stall_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.control_byte, out_ch.payload, out_ch.frame_end};
        n_checked <= n_checked + 1;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: result word with nothing expected: kind %0d ctrl %h data %h end %b",
                     $realtime, got.kind, got.control_byte, got.payload, got.frame_end);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.control_byte !== want.control_byte ||
              got.payload !== want.payload || got.frame_end !== want.frame_end) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"%0t: mismatch: expected kind %0d ctrl %h data %h end %b,",
                        " got kind %0d ctrl %h data %h end %b"}, $realtime,
                       want.kind, want.control_byte, want.payload, want.frame_end,
                       got.kind, got.control_byte, got.payload, got.frame_end);
          end
        end
      end
      stall_pct = (run_phase == 0) ? 85 : (run_phase == 1) ? 11 : 0;
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : run_test
    int sel;
    int len;
    logic [7:0] addr;

    // Directed opening: the first messages of a frame from a cleared store,
    // writes landing while the frame is running, the first and last bytes
    // of the store, and addresses just past the store and at the very top.
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_REFRESH, 8'hFF, 8'hFF);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_WRITE, 8'd0, 8'hFF);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_WRITE, 8'd12, 8'h55);
    queue_word(CMD_WRITE, 8'd84, 8'h80);
    queue_word(CMD_WRITE, 8'(STORE_BYTES - 1), 8'hAA);
    queue_word(CMD_WRITE, 8'(STORE_BYTES), 8'h11);
    queue_word(CMD_WRITE, 8'hFF, 8'hFF);
    queue_word(CMD_WRITE, 8'd96, 8'h01);
    queue_word(CMD_WRITE, 8'd11, 8'hFF);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_WRITE, 8'd0, 8'h00);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);
    queue_word(CMD_REFRESH, 8'h00, 8'h00);

    // Random part: long runs of ticks so that whole frames complete, short
    // bursts of writes mostly inside the store, and the odd fully random word.
    while (n_queued < WORD_TARGET) begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        len = $urandom_range(1, 60);
        repeat (len) queue_word(CMD_REFRESH, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (sel < 9) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          addr = ($urandom_range(9) == 0) ? 8'($urandom_range(STORE_BYTES, 255))
                                          : 8'($urandom_range(STORE_BYTES - 1));
          queue_word(CMD_WRITE, addr, 8'($urandom_range(255)));
        end
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) queue_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
      end
    end

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Poll on the falling edge so that nothing races the clocked blocks.
    do @(negedge clk); while (stim_words.size() != 0 || in_ch.valid);
    do @(negedge clk); while (n_taken != n_checked);
    // Leave time for stray result words after the last one is checked.
    repeat (40) @(negedge clk);

    if (pending_results.size() != 0) begin
      $display("%0d expected result words never arrived", pending_results.size());
      n_errors += pending_results.size();
    end
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
